>>> rtl/nfo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfo_pkg
// Shared types, constants and helpers of the nonlinear flux observer with PLL.
// ----------------------------------------------------------------------------
package nfo_pkg;

	typedef struct packed {
		logic [19:0] res;
		logic [23:0] ld;
		logic [23:0] lq;
		logic [31:0] gamma;
		logic [31:0] fms;
		logic [31:0] kp;
		logic [31:0] ki;
		logic [31:0] ts;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_RES   = 3'd0,
		REG_LD    = 3'd1,
		REG_LQ    = 3'd2,
		REG_GAMMA = 3'd3,
		REG_FMS   = 3'd4,
		REG_KP    = 3'd5,
		REG_KI    = 3'd6,
		REG_TS    = 3'd7
	} reg_idx_t;

	// Steps of the observer sequence, each one pass through the shared multiplier.
	typedef enum logic [4:0] {
		OP_RIA = 5'd0,
		OP_RIB = 5'd1,
		OP_LIA = 5'd2,
		OP_LIB = 5'd3,
		OP_SQA = 5'd4,
		OP_SQB = 5'd5,
		OP_G   = 5'd6,
		OP_CA  = 5'd7,
		OP_CB  = 5'd8,
		OP_FA  = 5'd9,
		OP_FB  = 5'd10,
		OP_EB  = 5'd11,
		OP_EA  = 5'd12,
		OP_P   = 5'd13,
		OP_I   = 5'd14,
		OP_IT  = 5'd15,
		OP_DR  = 5'd16,
		OP_DT  = 5'd17
	} op_t;

	typedef struct packed {
		logic       load_in;
		logic       mul_start;
		logic       wb;
		op_t        op;
		logic       cord_init;
		logic       cord_step;
		logic [3:0] iter;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic out_busy;
	} sts_t;

	localparam int unsigned CORD_ITERS = 16;
	localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd326016437;
	localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

	function automatic logic [31:0] atan_turn(input logic [3:0] i);
		logic [31:0] v;
		case (i)
			4'd0:  v = 32'd536870912;
			4'd1:  v = 32'd316933406;
			4'd2:  v = 32'd167458907;
			4'd3:  v = 32'd85004756;
			4'd4:  v = 32'd42667331;
			4'd5:  v = 32'd21354465;
			4'd6:  v = 32'd10679838;
			4'd7:  v = 32'd5340245;
			4'd8:  v = 32'd2670163;
			4'd9:  v = 32'd1335087;
			4'd10: v = 32'd667544;
			4'd11: v = 32'd333772;
			4'd12: v = 32'd166886;
			4'd13: v = 32'd83443;
			4'd14: v = 32'd41722;
			default: v = 32'd20861;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > I32_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < I32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Round a Q.29 value to Q1.14, half up, and clamp to plus or minus one.
	function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
		logic signed [34:0] t;
		logic signed [34:0] r;
		logic signed [15:0] o;
		t = 35'(v) + 35'sd16384;
		r = t >>> 15;
		if (r > 35'sd16384) begin
			o = 16'sd16384;
		end else if (r < -35'sd16384) begin
			o = -16'sd16384;
		end else begin
			o = r[15:0];
		end
		return o;
	endfunction

endpackage
`default_nettype wire

>>> rtl/nfo_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfo_in_if
// Input channel: one beat carries the alpha/beta voltages and currents.
// ----------------------------------------------------------------------------
interface nfo_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] volt_alpha;
	logic signed [15:0] volt_beta;
	logic signed [15:0] amp_alpha;
	logic signed [15:0] amp_beta;

	modport source (output valid, volt_alpha, volt_beta, amp_alpha, amp_beta, input ready);
	modport sink (input valid, volt_alpha, volt_beta, amp_alpha, amp_beta, output ready);
endinterface
`default_nettype wire

>>> rtl/nfo_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfo_out_if
// Output channel: one beat carries angle, sine, cosine and speed.
// ----------------------------------------------------------------------------
interface nfo_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rotor_angle;
	logic signed [15:0] angle_sine;
	logic signed [15:0] angle_cosine;
	logic signed [31:0] rotor_speed;

	modport source (output valid, rotor_angle, angle_sine, angle_cosine, rotor_speed,
		input ready);
	modport sink (input valid, rotor_angle, angle_sine, angle_cosine, rotor_speed,
		output ready);
endinterface
`default_nettype wire

>>> rtl/nfo_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfo_regs
// APB register file holding the motor and loop parameters.
// ----------------------------------------------------------------------------
module nfo_regs
	import nfo_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_RES:   cfg_q.res   <= pwdata[19:0];
				REG_LD:    cfg_q.ld    <= pwdata[23:0];
				REG_LQ:    cfg_q.lq    <= pwdata[23:0];
				REG_GAMMA: cfg_q.gamma <= pwdata;
				REG_FMS:   cfg_q.fms   <= pwdata;
				REG_KP:    cfg_q.kp    <= pwdata;
				REG_KI:    cfg_q.ki    <= pwdata;
				REG_TS:    cfg_q.ts    <= pwdata;
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RES:   prdata = 32'(cfg_q.res);
			REG_LD:    prdata = 32'(cfg_q.ld);
			REG_LQ:    prdata = 32'(cfg_q.lq);
			REG_GAMMA: prdata = cfg_q.gamma;
			REG_FMS:   prdata = cfg_q.fms;
			REG_KP:    prdata = cfg_q.kp;
			REG_KI:    prdata = cfg_q.ki;
			REG_TS:    prdata = cfg_q.ts;
			default:   prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/nfo_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfo_mul
// Shared scaled multiplier: sign * min(lim, (|a| * |b|) >> sh), built from
// two 32x32 partial products taken in successive cycles.
// ----------------------------------------------------------------------------
module nfo_mul
	import nfo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] a,
	input  wire logic signed [32:0] b,
	input  wire logic [5:0]         sh,
	input  wire logic               lim_i32,
	output logic                    done,
	output logic signed [63:0]      res
);
	logic [1:0]  phase_q;
	logic        done_q;
	logic [63:0] amag_q;
	logic [31:0] bmag_q;
	logic        neg_q;
	logic [5:0]  sh_q;
	logic        lim_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic signed [63:0] res_q;

	logic [31:0] mul_op;
	logic [63:0] prod;
	logic [95:0] full;
	logic [95:0] shf;
	logic [95:0] lim;
	logic [50:0] mag;

	assign mul_op = (phase_q == 2'd1) ? amag_q[31:0] : amag_q[63:32];
	assign prod   = 64'(mul_op) * 64'(bmag_q);
	assign full   = {hi_q, 32'd0} + 96'(lo_q);
	assign shf    = full >> sh_q;
	assign lim    = lim_q ? 96'(I32_MAX) : (96'd1 << 50);
	assign mag    = (shf > lim) ? lim[50:0] : shf[50:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == 2'd3);
			if (start) begin
				phase_q <= 2'd1;
			end else if (phase_q != 2'd0) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			amag_q <= a[63] ? 64'(-a) : 64'(a);
			bmag_q <= b[32] ? 32'(-b) : b[31:0];
			neg_q  <= a[63] ^ b[32];
			sh_q   <= sh;
			lim_q  <= lim_i32;
		end
		if (phase_q == 2'd1) lo_q <= prod;
		if (phase_q == 2'd2) hi_q <= prod;
		if (phase_q == 2'd3) begin
			res_q <= neg_q ? -$signed(64'(mag)) : $signed(64'(mag));
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule
`default_nettype wire

>>> rtl/nfo_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfo_dp
// Observer datapath: operand routing to the shared multiplier, write-back of
// the flux, PLL and angle state, the CORDIC and the output register.
// ----------------------------------------------------------------------------
module nfo_dp
	import nfo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire cfg_t               cfg,
	input  wire logic signed [15:0] volt_alpha,
	input  wire logic signed [15:0] volt_beta,
	input  wire logic signed [15:0] amp_alpha,
	input  wire logic signed [15:0] amp_beta,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic signed [15:0]      rotor_angle,
	output logic signed [15:0]      angle_sine,
	output logic signed [15:0]      angle_cosine,
	output logic signed [31:0]      rotor_speed
);
	logic signed [15:0] ua_q, ub_q, ia_q, ib_q;
	logic signed [39:0] ya_q, yb_q;
	logic signed [31:0] eta_a_q, eta_b_q;
	logic [39:0]        norm_q;
	logic signed [31:0] g_q;
	logic signed [43:0] deriv_a_q, deriv_b_q;
	logic signed [47:0] err_q;
	logic signed [51:0] pterm_q, iacc_q, drad_q;
	logic signed [31:0] omega_q;
	logic signed [31:0] flux_a_q, flux_b_q, si_q;
	logic [15:0]        angle_q;
	logic signed [15:0] sin_q, cos_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic               out_valid_q;
	logic signed [15:0] o_angle_q, o_sin_q, o_cos_q;
	logic signed [31:0] o_speed_q;

	logic signed [63:0] mul_a;
	logic signed [32:0] mul_b;
	logic [5:0]         mul_sh;
	logic               mul_lim;
	logic               mul_done;
	logic signed [63:0] mul_res;
	logic signed [31:0] si_new;
	logic signed [16:0] ang_s;
	logic signed [16:0] ang_f;
	logic               fold;
	logic signed [33:0] dx, dy, at;
	logic signed [33:0] xf, yf;

	nfo_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.sh      (mul_sh),
		.lim_i32 (mul_lim),
		.done    (mul_done),
		.res     (mul_res)
	);

	always_comb begin
		mul_a   = 64'(ia_q);
		mul_b   = $signed(33'(cfg.res));
		mul_sh  = 6'd0;
		mul_lim = 1'b0;
		case (cmd.op)
			OP_RIA: begin mul_a = 64'(ia_q); mul_b = $signed(33'(cfg.res)); end
			OP_RIB: begin mul_a = 64'(ib_q); mul_b = $signed(33'(cfg.res)); end
			OP_LIA: begin
				mul_a = 64'(ia_q); mul_b = $signed(33'(cfg.ld)); mul_sh = 6'd4;
			end
			OP_LIB: begin
				mul_a = 64'(ib_q); mul_b = $signed(33'(cfg.lq)); mul_sh = 6'd4;
			end
			OP_SQA: begin mul_a = 64'(eta_a_q); mul_b = 33'(eta_a_q); mul_sh = 6'd24; end
			OP_SQB: begin mul_a = 64'(eta_b_q); mul_b = 33'(eta_b_q); mul_sh = 6'd24; end
			OP_G: begin
				mul_a   = $signed(64'(cfg.fms)) - $signed(64'(norm_q));
				mul_b   = $signed(33'(cfg.gamma));
				mul_sh  = 6'd24;
				mul_lim = 1'b1;
			end
			OP_CA: begin mul_a = 64'(g_q); mul_b = 33'(eta_a_q); mul_sh = 6'd20; end
			OP_CB: begin mul_a = 64'(g_q); mul_b = 33'(eta_b_q); mul_sh = 6'd20; end
			OP_FA: begin
				mul_a = 64'(deriv_a_q); mul_b = $signed(33'(cfg.ts)); mul_sh = 6'd28;
			end
			OP_FB: begin
				mul_a = 64'(deriv_b_q); mul_b = $signed(33'(cfg.ts)); mul_sh = 6'd28;
			end
			OP_EB: begin mul_a = 64'(eta_b_q); mul_b = 33'(cos_q); end
			OP_EA: begin mul_a = 64'(eta_a_q); mul_b = 33'(sin_q); end
			OP_P: begin
				mul_a = 64'(err_q); mul_b = $signed(33'(cfg.kp)); mul_sh = 6'd50;
			end
			OP_I: begin
				mul_a = 64'(err_q); mul_b = $signed(33'(cfg.ki)); mul_sh = 6'd42;
			end
			OP_IT: begin
				mul_a = 64'(iacc_q); mul_b = $signed(33'(cfg.ts)); mul_sh = 6'd40;
			end
			OP_DR: begin
				mul_a = 64'(omega_q); mul_b = $signed(33'(cfg.ts)); mul_sh = 6'd16;
			end
			OP_DT: begin
				mul_a = 64'(drad_q); mul_b = $signed(33'(TURN_PER_RAD)); mul_sh = 6'd40;
			end
			default: ;
		endcase
	end

	assign si_new = sat32(64'(si_q) + mul_res);

	// Fold the angle into the right half plane by a half turn.
	assign ang_s = 17'($signed(angle_q));
	always_comb begin
		fold  = 1'b0;
		ang_f = ang_s;
		if (ang_s > 17'sd16384) begin
			ang_f = ang_s - 17'sd32768;
			fold  = 1'b1;
		end else if (ang_s < -17'sd16384) begin
			ang_f = ang_s + 17'sd32768;
			fold  = 1'b1;
		end
	end

	assign dx = cy_q >>> cmd.iter;
	assign dy = cx_q >>> cmd.iter;
	assign at = $signed(34'(atan_turn(cmd.iter)));
	assign xf = flip_q ? -cx_q : cx_q;
	assign yf = flip_q ? -cy_q : cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flux_a_q    <= '0;
			flux_b_q    <= '0;
			si_q        <= '0;
			angle_q     <= '0;
			sin_q       <= '0;
			cos_q       <= 16'sd16384;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wb) begin
				case (cmd.op)
					OP_FA:   flux_a_q <= sat32(64'(flux_a_q) + mul_res);
					OP_FB:   flux_b_q <= sat32(64'(flux_b_q) + mul_res);
					OP_IT:   si_q <= si_new;
					OP_DT:   angle_q <= angle_q + mul_res[15:0];
					default: ;
				endcase
			end
			if (cmd.fin) begin
				sin_q       <= to_q14(yf);
				cos_q       <= to_q14(xf);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ua_q <= volt_alpha;
			ub_q <= volt_beta;
			ia_q <= amp_alpha;
			ib_q <= amp_beta;
		end
		if (cmd.wb) begin
			case (cmd.op)
				OP_RIA:  ya_q <= 40'((64'(ua_q) <<< 16) - mul_res);
				OP_RIB:  yb_q <= 40'((64'(ub_q) <<< 16) - mul_res);
				OP_LIA:  eta_a_q <= sat32(64'(flux_a_q) - mul_res);
				OP_LIB:  eta_b_q <= sat32(64'(flux_b_q) - mul_res);
				OP_SQA:  norm_q <= mul_res[39:0];
				OP_SQB:  norm_q <= norm_q + mul_res[39:0];
				OP_G:    g_q <= mul_res[31:0];
				OP_CA:   deriv_a_q <= 44'(64'(ya_q) + mul_res);
				OP_CB:   deriv_b_q <= 44'(64'(yb_q) + mul_res);
				OP_EB:   err_q <= mul_res[47:0];
				OP_EA:   err_q <= 48'(64'(err_q) - mul_res);
				OP_P:    pterm_q <= mul_res[51:0];
				OP_I:    iacc_q <= mul_res[51:0];
				OP_IT:   omega_q <= sat32(64'(si_new) + 64'(pterm_q));
				OP_DR:   drad_q <= mul_res[51:0];
				default: ;
			endcase
		end
		if (cmd.cord_init) begin
			cx_q   <= CORDIC_X0;
			cy_q   <= '0;
			cz_q   <= 34'(ang_f) <<< 16;
			flip_q <= fold;
		end else if (cmd.cord_step) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + at;
			end
		end
		if (cmd.fin) begin
			o_angle_q <= $signed(angle_q);
			o_sin_q   <= to_q14(yf);
			o_cos_q   <= to_q14(xf);
			o_speed_q <= omega_q;
		end
	end

	assign sts.mul_done  = mul_done;
	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign rotor_angle   = o_angle_q;
	assign angle_sine    = o_sin_q;
	assign angle_cosine  = o_cos_q;
	assign rotor_speed   = o_speed_q;
endmodule
`default_nettype wire

>>> rtl/nfo_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfo_ctrl
// Sequencer: steps the datapath through the multiplier passes, the CORDIC
// iterations and the output load.
// ----------------------------------------------------------------------------
module nfo_ctrl
	import nfo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ISSUE = 6'b000010,
		S_WAIT  = 6'b000100,
		S_CINIT = 6'b001000,
		S_CORD  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t     state_q;
	op_t        op_q;
	logic [3:0] iter_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		cmd.iter      = iter_q;
		cmd.load_in   = (state_q == S_IDLE) && in_valid;
		cmd.mul_start = (state_q == S_ISSUE);
		cmd.wb        = (state_q == S_WAIT) && sts.mul_done;
		cmd.cord_init = (state_q == S_CINIT);
		cmd.cord_step = (state_q == S_CORD);
		cmd.fin       = (state_q == S_FIN) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_RIA;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= OP_RIA;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.mul_done) begin
						if (op_q == OP_DT) begin
							state_q <= S_CINIT;
						end else begin
							op_q    <= op_t'(op_q + 5'd1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_CINIT: begin
					iter_q  <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (iter_q == 4'(CORD_ITERS - 1)) begin
						state_q <= S_FIN;
					end else begin
						iter_q <= iter_q + 4'd1;
					end
				end
				S_FIN: begin
					if (!sts.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/nonlinear_flux_observer_pll.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nonlinear_flux_observer_pll
// Sensorless rotor flux observer with PI phase-locked loop and CORDIC.
//
// Usage: configure the eight parameters over the APB port (4-byte spaced,
// writes take effect on the access phase) while the block is idle. Each
// PWM period, present one beat of alpha/beta voltage and current on din.
// The block returns one beat on dout with the angle estimate, its sine and
// cosine and the unfiltered PLL speed.
// Sequence: each input beat is worked through eighteen passes of the single
// shared multiplier and then sixteen CORDIC iterations; din is not ready
// again until the result is loaded into the output register, and it is ready
// from the same cycle in which that result becomes valid.
// A finished result sits in the output register; a new input beat is taken
// while it waits. If dout is still stalled when the next result is done,
// the sequencer holds until it is taken.
// Reset clears flux, speed integral, angle, sine estimate and output valid,
// and sets the cosine estimate to one. No clearing pass is needed.
// ----------------------------------------------------------------------------
module nonlinear_flux_observer_pll
	import nfo_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	nfo_in_if.sink           din,
	nfo_out_if.source        dout
);
	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	nfo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nfo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nfo_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg          (cfg),
		.volt_alpha   (din.volt_alpha),
		.volt_beta    (din.volt_beta),
		.amp_alpha    (din.amp_alpha),
		.amp_beta     (din.amp_beta),
		.out_ready    (dout.ready),
		.out_valid    (dout.valid),
		.rotor_angle  (dout.rotor_angle),
		.angle_sine   (dout.angle_sine),
		.angle_cosine (dout.angle_cosine),
		.rotor_speed  (dout.rotor_speed)
	);
endmodule
`default_nettype wire

>>> rtl/nfo_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfo_check
// Port-level checks of the observer, bound to the top level.
// ----------------------------------------------------------------------------
module nfo_check (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] angle_sine,
	input wire logic signed [15:0] angle_cosine,
	input wire logic signed [31:0] rotor_speed
);
	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle_sine)
			&& $stable(angle_cosine) && $stable(rotor_speed))
		else $error("stalled result changed");

	// The block is busy, with din not ready, after taking a beat.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken while busy");

	// A new result only appears when the input side has been held off.
	a_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

	// Sine and cosine stay within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_sine <= 16'sd16384 && angle_sine >= -16'sd16384
			&& angle_cosine <= 16'sd16384 && angle_cosine >= -16'sd16384)
		else $error("sine or cosine out of range");
endmodule

bind nonlinear_flux_observer_pll nfo_check u_nfo_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (din.valid),
	.in_ready     (din.ready),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.angle_sine   (dout.angle_sine),
	.angle_cosine (dout.angle_cosine),
	.rotor_speed  (dout.rotor_speed)
);
`default_nettype wire

>>> sim/tb_nonlinear_flux_observer_pll.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nonlinear_flux_observer_pll
// Self-checking bench for the flux observer and PLL. Parameters are loaded
// over APB between phases. Voltage and current beats are driven with random
// gaps while the result side stalls at random. A bit-true scoreboard model
// predicts every result, and each result beat is checked in order.
// ----------------------------------------------------------------------------
module tb_nonlinear_flux_observer_pll;
	import nfo_pkg::*;

	typedef struct {
		logic signed [15:0] ua, ub, ia, ib;
	} sample_t;

	typedef struct {
		logic signed [15:0] angle, sine, cosine;
		logic signed [31:0] speed;
	} estimate_t;

	class flux_pll_scoreboard;
		localparam longint BIG = 64'sd1 << 50;
		cfg_t               cfg;
		logic signed [31:0] flux_a, flux_b, speed_acc;
		logic        [15:0] angle;
		logic signed [15:0] sin_est, cos_est;
		estimate_t          pending[$];
		int                 errors;

		function new();
			cfg = '0;
			flux_a = 0; flux_b = 0; speed_acc = 0;
			angle = 0; sin_est = 0; cos_est = 16384;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t r, logic [31:0] v);
			case (r)
				REG_RES:   cfg.res = v[19:0];
				REG_LD:    cfg.ld = v[23:0];
				REG_LQ:    cfg.lq = v[23:0];
				REG_GAMMA: cfg.gamma = v;
				REG_FMS:   cfg.fms = v;
				REG_KP:    cfg.kp = v;
				REG_KI:    cfg.ki = v;
				REG_TS:    cfg.ts = v;
			endcase
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// Truncation toward zero.
		function longint trunc_shr(longint v, int s);
			longint unsigned m;
			m = (v < 0) ? -v : v;
			m = m >> s;
			return (v < 0) ? -longint'(m) : longint'(m);
		endfunction

		// Scaled product, magnitude truncated and limited to lim.
		function longint scale(longint a, logic [31:0] b, int s, longint lim);
			longint unsigned m;
			logic [127:0]    p;
			longint unsigned r;
			m = (a < 0) ? -a : a;
			p = {64'd0, m} * {96'd0, b};
			p = p >> s;
			r = (p[127:64] != 0) ? '1 : p[63:0];
			if (r > longint'(lim)) r = lim;
			return (a < 0) ? -longint'(r) : longint'(r);
		endfunction

		function logic signed [15:0] round_q14(longint v);
			longint r;
			r = (v + 16384) >>> 15;
			if (r > 16384) r = 16384;
			if (r < -16384) r = -16384;
			return r[15:0];
		endfunction

		function void sin_cos(logic [15:0] ang, output logic signed [15:0] s,
			output logic signed [15:0] c);
			longint a, x, y, z, dx, dy;
			bit      flip;
			a = longint'($signed(ang));
			flip = 0;
			if (a > 16384) begin
				a -= 32768; flip = 1;
			end else if (a < -16384) begin
				a += 32768; flip = 1;
			end
			z = a * 65536;
			x = 326016437;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(atan_turn(i[3:0]));
				end else begin
					x += dx; y -= dy; z += longint'(atan_turn(i[3:0]));
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			s = round_q14(y);
			c = round_q14(x);
		endfunction

		function longint next_flux(longint x, longint eta, longint emf, longint g);
			longint deriv;
			deriv = emf + trunc_shr(g * eta, 20);
			return sat(x + scale(deriv, cfg.ts, 28, BIG));
		endfunction

		function void note_input(sample_t it);
			longint    ya, yb, eta_a, eta_b, g, err, pterm, iacc, omega, drad, dth;
			longint    nxt;
			longint unsigned norm;
			estimate_t e;
			ya = longint'(it.ua) * 65536 - longint'(cfg.res) * longint'(it.ia);
			yb = longint'(it.ub) * 65536 - longint'(cfg.res) * longint'(it.ib);
			eta_a = sat(longint'(flux_a) - trunc_shr(longint'(cfg.ld) * longint'(it.ia), 4));
			eta_b = sat(longint'(flux_b) - trunc_shr(longint'(cfg.lq) * longint'(it.ib), 4));
			norm = (longint'(eta_a * eta_a) >> 24) + (longint'(eta_b * eta_b) >> 24);
			g = scale(longint'(cfg.fms) - longint'(norm), cfg.gamma, 24, 64'sd2147483647);
			nxt = next_flux(flux_a, eta_a, ya, g);
			flux_a = nxt[31:0];
			nxt = next_flux(flux_b, eta_b, yb, g);
			flux_b = nxt[31:0];
			err = eta_b * longint'(cos_est) - eta_a * longint'(sin_est);
			pterm = scale(err, cfg.kp, 50, BIG);
			iacc = scale(err, cfg.ki, 42, BIG);
			nxt = sat(longint'(speed_acc) + scale(iacc, cfg.ts, 40, BIG));
			speed_acc = nxt[31:0];
			omega = sat(longint'(speed_acc) + pterm);
			drad = scale(omega, cfg.ts, 16, BIG);
			dth = scale(drad, TURN_PER_RAD, 40, BIG);
			angle = angle + dth[15:0];
			sin_cos(angle, sin_est, cos_est);
			e.angle = angle;
			e.sine = sin_est;
			e.cosine = cos_est;
			e.speed = omega[31:0];
			pending.push_back(e);
		endfunction

		function void check(estimate_t got);
			estimate_t w;
			if (pending.size() == 0) begin
				$display("%0t: result beat with nothing expected: angle %0d speed %0d",
					$time, got.angle, got.speed);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.angle !== w.angle) begin
				$display("%0t: rotor_angle expected %0d actual %0d", $time, w.angle, got.angle);
				errors++;
			end
			if (got.sine !== w.sine) begin
				$display("%0t: angle_sine expected %0d actual %0d", $time, w.sine, got.sine);
				errors++;
			end
			if (got.cosine !== w.cosine) begin
				$display("%0t: angle_cosine expected %0d actual %0d", $time, w.cosine,
					got.cosine);
				errors++;
			end
			if (got.speed !== w.speed) begin
				$display("%0t: rotor_speed expected %0d actual %0d", $time, w.speed, got.speed);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	nfo_in_if  din();
	nfo_out_if dout();

	flux_pll_scoreboard sb;
	bit                 no_stall;

	nonlinear_flux_observer_pll i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.din    (din.sink),
		.dout   (dout.source)
	);

	always #4 clk = ~clk;

	task automatic reg_write(reg_idx_t r, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(r, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] res, logic [31:0] ld, logic [31:0] lq,
		logic [31:0] gamma, logic [31:0] fms, logic [31:0] kp, logic [31:0] ki,
		logic [31:0] ts);
		reg_write(REG_RES, res);
		reg_write(REG_LD, ld);
		reg_write(REG_LQ, lq);
		reg_write(REG_GAMMA, gamma);
		reg_write(REG_FMS, fms);
		reg_write(REG_KP, kp);
		reg_write(REG_KI, ki);
		reg_write(REG_TS, ts);
	endtask

	task automatic wait_drained();
		din.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// Hold the beat until it is taken. valid is left high when no gap is drawn, so that the next
	// beat can follow without a gap.
	task automatic send(sample_t it);
		int gap;
		din.valid <= 1'b1;
		din.volt_alpha <= it.ua;
		din.volt_beta <= it.ub;
		din.amp_alpha <= it.ia;
		din.amp_beta <= it.ib;
		do @(posedge clk); while (!din.ready);
		sb.note_input(it);
		gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
		if ($urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic sample_t rand_sample(bit full);
		sample_t s;
		if (full) begin
			s.ua = 16'($urandom); s.ub = 16'($urandom);
			s.ia = 16'($urandom); s.ib = 16'($urandom);
		end else begin
			s.ua = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
			s.ub = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
			s.ia = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
			s.ib = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
		end
		return s;
	endfunction

	task automatic run_random(int n);
		for (int k = 0; k < n; k++) send(rand_sample($urandom_range(0, 3) == 0));
	endtask

	task automatic directed();
		logic signed [15:0] ext[4] = '{16'sh7fff, -16'sh8000, 16'sd0, -16'sd1};
		sample_t s;
		for (int k = 0; k < 4; k++) begin
			s.ua = ext[k]; s.ub = ext[(k + 1) % 4]; s.ia = ext[(k + 2) % 4];
			s.ib = ext[(k + 3) % 4];
			send(s);
		end
	endtask

	// Result side: random stalls, mostly short, a few long, some stall-free spans.
	initial begin
		int      stall;
		estimate_t r;
		stall = 0;
		dout.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (dout.valid && dout.ready) begin
				r.angle = dout.rotor_angle;
				r.sine = dout.angle_sine;
				r.cosine = dout.angle_cosine;
				r.speed = dout.rotor_speed;
				sb.check(r);
			end
			if (stall > 0) begin
				stall--;
				dout.ready <= 1'b0;
			end else if (!no_stall && $urandom_range(0, 7) == 0) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
					: $urandom_range(1, 5);
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= 1'b1;
			end
		end
	end

	initial begin
		#40ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		din.valid = 1'b0;
		din.volt_alpha = '0; din.volt_beta = '0; din.amp_alpha = '0; din.amp_beta = '0;
		no_stall = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All parameters zero: state must hold still.
		directed();
		run_random(20);
		wait_drained();

		// A plausible small drive: 20 kHz sampling, moderate gains.
		write_all(32'd6554, 32'd8389, 32'd10066, 32'd25600, 32'd4294967,
			32'd655360, 32'd65536000, 32'd214748);
		directed();
		no_stall = 1;
		run_random(200);
		wait_drained();
		no_stall = 0;
		run_random(300);

		// Every parameter at its top value, so every saturation is hit.
		wait_drained();
		write_all('1, '1, '1, '1, '1, '1, '1, '1);
		directed();
		run_random(150);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_all($urandom_range(0, 65535), $urandom_range(0, 1 << 20),
				$urandom_range(0, 1 << 20), $urandom, $urandom,
				$urandom_range(0, 1 << 24), $urandom, $urandom_range(1 << 12, 1 << 22));
			run_random(150);
		end
		wait_drained();
		write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
		run_random(50);

		din.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
